// ===== rtl/jdm_pkg.sv =====
// ----------------------------------------------------------------------------
// jdm_pkg
// Shared types and constants of the joystick dead-zone to control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jdm_pkg;

    localparam int SAMPLE_W = 14;
    localparam int WINDOW_W = 13;
    localparam int CHAN_W   = 4;

    // configuration port
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_CENTER = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam logic [SAMPLE_W-1:0] CENTER_RESET = 14'd8192;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 13'd1200;

    // modulation = floor(excess * 127 / 8678), by reciprocal multiply
    localparam int RECIP_W   = 22;
    localparam int PROD_W    = SAMPLE_W + RECIP_W;
    localparam int MOD_SHIFT = 28;
    localparam int MOD_W     = 7;
    localparam logic [RECIP_W-1:0]  MOD_RECIP      = 22'd3928475;
    localparam logic [SAMPLE_W-1:0] MOD_SAT_EXCESS = 14'd8747;
    localparam logic [MOD_W-1:0]    MOD_MAX        = 7'd127;

    localparam logic KIND_MOD   = 1'b0;
    localparam logic KIND_PITCH = 1'b1;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam logic [QCNT_W-1:0] QUEUE_ROOM_MAX = 3'd2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_SEND = 3'b010,
        MODE_STOP = 3'b100
    } t_mode;

    typedef struct packed {
        logic [SAMPLE_W-1:0] center;
        logic [WINDOW_W-1:0] window;
    } t_cfg;

    typedef struct packed {
        logic                emit;
        logic [SAMPLE_W-1:0] value;
    } t_axis_res;

    typedef struct packed {
        logic                kind;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/jdm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// jdm_cfg_regs
// Register file for center level and dead window, written over the bus port.
// ----------------------------------------------------------------------------
`default_nettype none

module jdm_cfg_regs
    import jdm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [SAMPLE_W-1:0] r_center;
    logic [WINDOW_W-1:0] r_window;
    logic                wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RESET;
            r_window <= WINDOW_RESET;
        end else if (wr_en) begin
            case (paddr[REG_SEL_BIT])
                REG_CENTER: r_center <= pwdata[SAMPLE_W-1:0];
                REG_WINDOW: r_window <= pwdata[WINDOW_W-1:0];
                default:    r_center <= r_center;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_CENTER: prdata = DATA_W'(r_center);
            REG_WINDOW: prdata = DATA_W'(r_window);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.center = r_center;
    assign o_cfg.window = r_window;

endmodule

`default_nettype wire

// ===== rtl/jdm_axis.sv =====
// ----------------------------------------------------------------------------
// jdm_axis
// One axis machine: dead-zone test, value computation and mode register.
// ----------------------------------------------------------------------------
`default_nettype none

module jdm_axis
    import jdm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic                i_pitch,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire t_cfg                i_cfg,
    output t_axis_res                o_res
);

    t_mode               r_mode;
    t_mode               n_mode;
    logic signed [15:0]  s_sample;
    logic signed [15:0]  s_high;
    logic signed [15:0]  s_low;
    logic signed [15:0]  s_excess;
    logic signed [15:0]  s_pitch;
    logic                above;
    logic                below;
    logic [SAMPLE_W-1:0] excess;
    logic [PROD_W-1:0]   prod;
    logic [MOD_W-1:0]    mod_val;
    logic [SAMPLE_W-1:0] live_val;
    logic [SAMPLE_W-1:0] rest_val;

    always_comb begin
        s_sample = signed'({2'b00, i_sample});
        s_high   = signed'({2'b00, i_cfg.center}) + signed'({3'b000, i_cfg.window});
        s_low    = signed'({2'b00, i_cfg.center}) - signed'({3'b000, i_cfg.window});
        above    = s_sample > s_high;
        below    = s_sample < s_low;
        s_excess = above ? (s_sample - s_high) : (s_low - s_sample);
        excess   = s_excess[SAMPLE_W-1:0];
        s_pitch  = above ? (s_sample - signed'({3'b000, i_cfg.window}))
                         : (s_sample + signed'({3'b000, i_cfg.window}));
    end

    // reciprocal is exact for every excess below the saturation point
    assign prod    = PROD_W'(excess) * PROD_W'(MOD_RECIP);
    assign mod_val = (excess >= MOD_SAT_EXCESS) ? MOD_MAX : prod[MOD_SHIFT +: MOD_W];

    assign live_val = i_pitch ? s_pitch[SAMPLE_W-1:0] : SAMPLE_W'(mod_val);
    assign rest_val = i_pitch ? i_cfg.center : '0;

    always_comb begin
        o_res.emit  = 1'b0;
        o_res.value = live_val;
        n_mode      = r_mode;
        case (r_mode)
            MODE_SEND: begin
                if (above || below) begin
                    o_res.emit = 1'b1;
                end else begin
                    n_mode = MODE_STOP;
                end
            end
            MODE_STOP: begin
                o_res.emit  = 1'b1;
                o_res.value = rest_val;
                n_mode      = MODE_IDLE;
            end
            default: begin
                n_mode = (above || below) ? MODE_SEND : MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (i_step) begin
            r_mode <= n_mode;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jdm_out_queue.sv =====
// ----------------------------------------------------------------------------
// jdm_out_queue
// Four-entry result queue taking up to two words per cycle, one out.
// ----------------------------------------------------------------------------
`default_nettype none

module jdm_out_queue
    import jdm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push_a,
    input  wire logic    i_push_b,
    input  wire t_result i_entry_a,
    input  wire t_result i_entry_b,
    input  wire logic    i_pop,
    output t_result      o_head,
    output logic         o_valid,
    output logic         o_room
);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   wr_ptr_b;
    logic [QCNT_W-1:0]   push_n;
    logic                pop_ok;

    assign wr_ptr_b = r_wr_ptr + QPTR_W'(1);
    assign push_n   = QCNT_W'(i_push_a) + QCNT_W'(i_push_b);
    assign pop_ok   = i_pop & o_valid;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= QUEUE_ROOM_MAX);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wr_ptr] <= i_entry_a;
        end
        if (i_push_b) begin
            r_mem[wr_ptr_b] <= i_entry_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[QPTR_W-1:0];
            r_count  <= r_count + push_n - QCNT_W'(pop_ok);
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/joystick_deadzone_to_midi_controls_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_deadzone_to_midi_controls_unit
// Turns x/y joystick sample pairs into modulation and pitch control words.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one sample pair and a channel.
// A word is taken at an edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry result words, zero to two
// per sample pair; the x (modulation) word comes before the y (pitch) word and
// the final word of a pair has o_last set. A pair with no result gives no word.
// A pair taken into the input register is processed by the axis machines once
// the result queue has room, and its words are written to the queue, whose head
// drives the output. One pair is taken per cycle while two queue slots are free;
// the output port moves one word per cycle unless the receiver stalls.
// When the receiver stalls, the queue holds its words and the head word stays
// put; once fewer than two slots are free the input register holds and
// o_in_stall rises.
// Reset (synchronous, active low) empties the queue and the input register,
// returns both axes to idle and loads center 8192 and window 1200.
// Registers: center at byte address 0, dead window at byte address 4.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_deadzone_to_midi_controls_unit
    import jdm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [SAMPLE_W-1:0] i_x_sample,
    input  wire logic [SAMPLE_W-1:0] i_y_sample,
    input  wire logic [CHAN_W-1:0]   i_midi_channel,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_message_kind,
    output logic      [CHAN_W-1:0]   o_channel_out,
    output logic      [SAMPLE_W-1:0] o_control_value,
    output logic                     o_last,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready
);

    t_cfg                cfg;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_x;
    logic [SAMPLE_W-1:0] r_y;
    logic [CHAN_W-1:0]   r_ch;
    logic                room;
    logic                advance;
    logic                in_take;
    t_axis_res           x_res;
    t_axis_res           y_res;
    t_result             entry_x;
    t_result             entry_y;
    t_result             entry_a;
    t_result             head;
    logic                push_a;
    logic                push_b;

    jdm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance    = r_in_valid & room;
    assign o_in_stall = r_in_valid & ~room;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x  <= i_x_sample;
            r_y  <= i_y_sample;
            r_ch <= i_midi_channel;
        end
    end

    jdm_axis u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_pitch  (KIND_MOD),
        .i_sample (r_x),
        .i_cfg    (cfg),
        .o_res    (x_res)
    );

    jdm_axis u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_pitch  (KIND_PITCH),
        .i_sample (r_y),
        .i_cfg    (cfg),
        .o_res    (y_res)
    );

    // x word goes first; the pitch word closes the pair when there is one
    always_comb begin
        entry_x.kind    = KIND_MOD;
        entry_x.channel = r_ch;
        entry_x.value   = x_res.value;
        entry_x.last    = ~y_res.emit;
        entry_y.kind    = KIND_PITCH;
        entry_y.channel = r_ch;
        entry_y.value   = y_res.value;
        entry_y.last    = 1'b1;
        entry_a         = x_res.emit ? entry_x : entry_y;
        push_a          = advance & (x_res.emit | y_res.emit);
        push_b          = advance & x_res.emit & y_res.emit;
    end

    jdm_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_a  (push_a),
        .i_push_b  (push_b),
        .i_entry_a (entry_a),
        .i_entry_b (entry_y),
        .i_pop     (~i_out_stall),
        .o_head    (head),
        .o_valid   (o_out_valid),
        .o_room    (room)
    );

    assign o_message_kind  = head.kind;
    assign o_channel_out   = head.channel;
    assign o_control_value = head.value;
    assign o_last          = head.last;

endmodule

`default_nettype wire

// ===== rtl/jdm_checker.sv =====
// ----------------------------------------------------------------------------
// jdm_checker
// Port-level checks of the joystick dead-zone to control unit.
// ----------------------------------------------------------------------------
`default_nettype none

module jdm_checker
    import jdm_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire logic                o_message_kind,
    input wire logic [CHAN_W-1:0]   o_channel_out,
    input wire logic [SAMPLE_W-1:0] o_control_value,
    input wire logic                o_last
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_message_kind)
        && $stable(o_channel_out) && $stable(o_control_value) && $stable(o_last))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_kind == KIND_MOD |-> o_control_value <= 14'd127)
        else $error("modulation value above 127");

    a_pitch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_kind == KIND_PITCH |-> o_last)
        else $error("pitch word not marked last");

    // a modulation word that is not last is followed at once by its pitch word
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=>
        o_out_valid && o_message_kind == KIND_PITCH && $stable(o_channel_out))
        else $error("pitch word missing after open modulation word");

endmodule

bind joystick_deadzone_to_midi_controls_unit jdm_checker u_jdm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_message_kind  (o_message_kind),
    .o_channel_out   (o_channel_out),
    .o_control_value (o_control_value),
    .o_last          (o_last)
);

`default_nettype wire

// ===== bench/joystick_deadzone_to_midi_controls_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_deadzone_to_midi_controls_unit_test
// Self-checking bench for the joystick dead-zone to control word unit.
// Sample pairs go in through a valid/stall channel. An in-bench model of both
// axis machines predicts the modulation and pitch words for each pair, and
// the words that come out are compared with those predictions in order.
// Center and window are changed over APB between phases, the extremes among
// them. Both channels idle at random, and the output is held off twice for a
// long stretch to fill the unit.
// ----------------------------------------------------------------------------

module joystick_deadzone_to_midi_controls_unit_test;
    import jdm_pkg::*;

    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int MOD_DIVISOR = 17356;
    localparam int MOD_SCALE   = 127;
    localparam int SETTLE      = 8;
    localparam int OUT_HOLD    = 300;
    localparam int QUIET_LIMIT = 3000;

    typedef enum int {
        REGION_ABOVE,
        REGION_BELOW,
        REGION_INSIDE,
        REGION_EDGE,
        REGION_ANY
    } t_region;

    // tracks both axis machines and the words they are due to send
    class control_word_board;
        t_result             expected[$];
        logic [SAMPLE_W-1:0] center;
        logic [WINDOW_W-1:0] window;
        t_mode               x_mode;
        t_mode               y_mode;
        int                  errors;

        function new();
            center = CENTER_RESET;
            window = WINDOW_RESET;
            x_mode = MODE_IDLE;
            y_mode = MODE_IDLE;
            errors = 0;
        endfunction

        function bit advance_axis(inout t_mode mode, input int sample, input logic kind,
                                  output logic [SAMPLE_W-1:0] value);
            int  c;
            int  w;
            int  hi;
            int  lo;
            int  v;
            int  excess;
            bit  above;
            bit  below;
            c     = int'(center);
            w     = int'(window);
            hi    = c + w;
            lo    = c - w;
            above = sample > hi;
            below = sample < lo;
            value = '0;
            case (mode)
                MODE_SEND: begin
                    if (above || below) begin
                        if (kind == KIND_PITCH) begin
                            v = above ? sample - w : sample + w;
                        end else begin
                            excess = above ? sample - hi : lo - sample;
                            v = (2 * excess * MOD_SCALE) / MOD_DIVISOR;
                            if (v > int'(MOD_MAX)) v = int'(MOD_MAX);
                        end
                        value = v[SAMPLE_W-1:0];
                        return 1'b1;
                    end
                    mode = MODE_STOP;
                    return 1'b0;
                end
                MODE_STOP: begin
                    // rest word goes out whatever the sample is
                    value = (kind == KIND_PITCH) ? center : '0;
                    mode  = MODE_IDLE;
                    return 1'b1;
                end
                default: begin
                    mode = (above || below) ? MODE_SEND : MODE_IDLE;
                    return 1'b0;
                end
            endcase
        endfunction

        function void note_pair(logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys,
                                logic [CHAN_W-1:0] ch);
            logic [SAMPLE_W-1:0] vx;
            logic [SAMPLE_W-1:0] vy;
            bit                  got_x;
            bit                  got_y;
            got_x = advance_axis(x_mode, int'(xs), KIND_MOD, vx);
            got_y = advance_axis(y_mode, int'(ys), KIND_PITCH, vy);
            if (got_x) expected.push_back(t_result'{KIND_MOD, ch, vx, !got_y});
            if (got_y) expected.push_back(t_result'{KIND_PITCH, ch, vy, 1'b1});
        endfunction

        function int pending();
            return expected.size();
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_word(logic kind, logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] value,
                        logic last);
            t_result want;
            if (expected.size() == 0) begin
                report($sformatf("unexpected word kind %0d ch %0d value %0d last %0d",
                                 kind, ch, value, last));
                return;
            end
            want = expected.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, wanted %0d", kind, want.kind));
            if (ch !== want.channel)
                report($sformatf("channel %0d, wanted %0d", ch, want.channel));
            if (value !== want.value)
                report($sformatf("value %0d, wanted %0d (kind %0d)", value, want.value,
                                 want.kind));
            if (last !== want.last)
                report($sformatf("last %0d, wanted %0d", last, want.last));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [SAMPLE_W-1:0] i_x_sample;
    logic [SAMPLE_W-1:0] i_y_sample;
    logic [CHAN_W-1:0]   i_midi_channel;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_message_kind;
    logic [CHAN_W-1:0]   o_channel_out;
    logic [SAMPLE_W-1:0] o_control_value;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    control_word_board sb;
    bit                idle_on;
    bit                hold_req;
    t_region           region[2];
    int                run_left[2];

    joystick_deadzone_to_midi_controls_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_x_sample      (i_x_sample),
        .i_y_sample      (i_y_sample),
        .i_midi_channel  (i_midi_channel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_message_kind  (o_message_kind),
        .o_channel_out   (o_channel_out),
        .o_control_value (o_control_value),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task send_pair(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
                   input logic [CHAN_W-1:0] ch);
        while (idle_on && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_x_sample     <= xs;
        i_y_sample     <= ys;
        i_midi_channel <= ch;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pair(xs, ys, ch);
    endtask

    task write_reg(input logic idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << REG_SEL_BIT;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_CENTER) sb.center = data[SAMPLE_W-1:0];
        else sb.window = data[WINDOW_W-1:0];
    endtask

    // wait until every predicted word is out, then let the pipeline empty
    task settle_out();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task set_levels(input logic [SAMPLE_W-1:0] c, input logic [WINDOW_W-1:0] w);
        logic [DATA_W-1:0] word;
        settle_out();
        // upper bits are junk and must be ignored
        word = $urandom();
        word[SAMPLE_W-1:0] = c;
        write_reg(REG_CENTER, word);
        word = $urandom();
        word[WINDOW_W-1:0] = w;
        write_reg(REG_WINDOW, word);
    endtask

    function logic [SAMPLE_W-1:0] draw_sample(t_region r);
        int hi;
        int lo;
        int e;
        hi = int'(sb.center) + int'(sb.window);
        lo = int'(sb.center) - int'(sb.window);
        case (r)
            REGION_ABOVE:  if (hi < SAMPLE_MAX)
                return SAMPLE_W'($urandom_range(SAMPLE_MAX, hi + 1));
            REGION_BELOW:  if (lo > 0) return SAMPLE_W'($urandom_range(lo - 1, 0));
            REGION_INSIDE: begin
                return SAMPLE_W'($urandom_range((hi > SAMPLE_MAX) ? SAMPLE_MAX : hi,
                                                (lo < 0) ? 0 : lo));
            end
            REGION_EDGE: begin
                case ($urandom_range(3))
                    0:       e = hi;
                    1:       e = hi + 1;
                    2:       e = lo;
                    default: e = lo - 1;
                endcase
                if (e < 0) e = 0;
                if (e > SAMPLE_MAX) e = SAMPLE_MAX;
                return SAMPLE_W'(e);
            end
            default: ;
        endcase
        return SAMPLE_W'($urandom_range(SAMPLE_MAX));
    endfunction

    // each axis stays in one region for a few pairs so that arm, send and stop
    // sequences come up often
    task run_random(input int count, input int hold_at);
        logic [SAMPLE_W-1:0] s[2];
        int                  r;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            for (int a = 0; a < 2; a++) begin
                if (run_left[a] == 0) begin
                    r = $urandom_range(99);
                    if (r < 30) region[a] = REGION_ABOVE;
                    else if (r < 60) region[a] = REGION_BELOW;
                    else if (r < 85) region[a] = REGION_INSIDE;
                    else if (r < 95) region[a] = REGION_EDGE;
                    else region[a] = REGION_ANY;
                    run_left[a] = $urandom_range(6, 1);
                end
                run_left[a]--;
                s[a] = draw_sample(region[a]);
            end
            send_pair(s[0], s[1], CHAN_W'($urandom_range(15)));
        end
    endtask

    // output side
    initial begin
        i_out_stall = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                sb.check_word(o_message_kind, o_channel_out, o_control_value, o_last);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (OUT_HOLD) @(posedge i_clk);
            end
            i_out_stall <= idle_on && ($urandom_range(99) < 33);
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("%0t timeout with %0d words still pending", $time, sb.pending());
        $display("joystick_deadzone_to_midi_controls_unit regression: fail");
        $finish;
    end

    initial begin
        sb             = new();
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        run_left       = '{0, 0};
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_x_sample     = '0;
        i_y_sample     = '0;
        i_midi_channel = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset levels: center 8192, window 1200, zone 6992..9392
        send_pair(14'd8192, 14'd8192, 4'd0);    // both stay idle
        send_pair(14'd16383, 14'd0, 4'd15);     // both arm, nothing out
        send_pair(14'd16383, 14'd0, 4'd15);     // full scale both ways
        send_pair(14'd9393, 14'd16383, 4'd3);   // one past the upper edge
        send_pair(14'd9392, 14'd9392, 4'd5);    // on the edge counts as inside
        send_pair(14'd0, 14'd0, 4'd10);         // rest words, back to idle
        send_pair(14'd6991, 14'd6992, 4'd0);    // x arms below, y on lower edge
        send_pair(14'd0, 14'd6992, 4'd15);      // only x sends
        send_pair(14'd8192, 14'd8192, 4'd7);    // x stops
        send_pair(14'd8192, 14'd8192, 4'd8);    // x rest word alone
        send_pair(14'd8192, 14'd16383, 4'd12);  // y arms alone
        send_pair(14'd16383, 14'd9393, 4'd1);   // x arms, y sends alone
        run_random(150, -1);

        // zero window at the bottom: modulation rounding and saturation
        set_levels(14'd0, 13'd0);
        send_pair(14'd8677, 14'd1, 4'd2);
        send_pair(14'd8677, 14'd16383, 4'd2);
        send_pair(14'd8678, 14'd1, 4'd4);
        send_pair(14'd8747, 14'd8192, 4'd9);
        send_pair(14'd16383, 14'd16383, 4'd14);
        send_pair(14'd0, 14'd0, 4'd6);
        send_pair(14'd16383, 14'd16383, 4'd11);
        run_random(200, -1);

        set_levels(14'd16383, 13'd8191);
        run_random(150, -1);
        set_levels(14'd0, 13'd8191);
        run_random(150, 60);
        set_levels(14'd16383, 13'd0);
        run_random(150, -1);

        for (int p = 0; p < 5; p++) begin
            set_levels(SAMPLE_W'($urandom_range(SAMPLE_MAX)),
                       (p == 2) ? WINDOW_W'($urandom_range(8191))
                                : WINDOW_W'($urandom_range(1500)));
            idle_on = (p != 1);
            run_random(150, (p == 3) ? 100 : -1);
        end
        idle_on = 1'b1;

        settle_out();
        if (sb.errors == 0) begin
            $display("joystick_deadzone_to_midi_controls_unit regression: pass");
        end else begin
            $display("joystick_deadzone_to_midi_controls_unit regression: fail");
        end
        $finish;
    end

endmodule
